// ----- rtl/core/background_frame_key_macros.svh -----
// Assertion macros shared by the background frame key RTL.
`ifndef BACKGROUND_FRAME_KEY_MACROS_SVH
`define BACKGROUND_FRAME_KEY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("background_frame_key assertion failed");

// Next-cycle implication, disabled during reset.
`define BFK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("background_frame_key assertion failed");

`endif

// ----- rtl/core/bfk_pkg.sv -----
// Package with the types and constants of the background frame key block.
`default_nettype none

package bfk_pkg;

   localparam int STORE_WORDS = 131072;
   localparam int ADDR_W = $clog2(STORE_WORDS);
   localparam int POS_W = ADDR_W + 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int RANGE_W = 9;

   localparam logic [31:0] BG_RESET_WORD = 32'h0080_0080;
   localparam logic [7:0] LANE_MID = 8'd128;
   localparam logic [7:0] LANE_ZERO = 8'd0;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_ARM = 1'b1
   } bfk_op_type;

   typedef enum logic [1:0] {
      REG_PIXEL_MODE = 2'd0,
      REG_Y_RANGE = 2'd1,
      REG_U_RANGE = 2'd2,
      REG_V_RANGE = 2'd3
   } bfk_reg_type;

   typedef enum logic {
      MODE_RGBA = 1'b0,
      MODE_YUV = 1'b1
   } bfk_mode_type;

   typedef struct packed {
      bfk_op_type opcode;
      logic [7:0] lane0;
      logic [7:0] lane1;
      logic [7:0] lane2;
      logic [7:0] lane3;
      logic last_in_frame;
   } bfk_req_type;

   typedef struct packed {
      logic [7:0] out_lane0;
      logic [7:0] out_lane1;
      logic [7:0] out_lane2;
      logic [7:0] out_lane3;
      logic out_last;
      logic is_background;
   } bfk_rsp_type;

   typedef struct packed {
      bfk_mode_type pixel_mode;
      logic [RANGE_W-1:0] y_range;
      logic [RANGE_W-1:0] u_range;
      logic [RANGE_W-1:0] v_range;
   } bfk_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/bfk_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bfk_csr.sv -----
// Configuration registers of the background frame key behind an APB-style port.
`default_nettype none

module bfk_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [bfk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [bfk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output bfk_pkg::bfk_cfg_type cfg
);

   import bfk_pkg::*;

   bfk_cfg_type cfg_ff;
   bfk_cfg_type cfg_in;
   bfk_reg_type reg_sel;
   logic wr_beat;

   assign reg_sel = bfk_reg_type'(csr_paddr[3:2]);
   assign wr_beat = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (reg_sel)
            REG_PIXEL_MODE: cfg_in.pixel_mode = bfk_mode_type'(csr_pwdata[0]);
            REG_Y_RANGE: cfg_in.y_range = csr_pwdata[RANGE_W-1:0];
            REG_U_RANGE: cfg_in.u_range = csr_pwdata[RANGE_W-1:0];
            REG_V_RANGE: cfg_in.v_range = csr_pwdata[RANGE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pixel_mode: MODE_RGBA, y_range: '0, u_range: '0, v_range: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PIXEL_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.pixel_mode);
         REG_Y_RANGE: csr_prdata = CSR_DATA_W'(cfg_ff.y_range);
         REG_U_RANGE: csr_prdata = CSR_DATA_W'(cfg_ff.u_range);
         REG_V_RANGE: csr_prdata = CSR_DATA_W'(cfg_ff.v_range);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/background_frame_key.sv -----
// A pixel beat passes the s1 stage register and then the output register.
// Throughput: one beat per cycle while rsp_stall does not hold the output; the store
// RAM read and the compare stage both pipeline. Arm beats produce no output beat.
// Reset is synchronous; the store needs no clearing pass, since a fill count marks
// the words written so far and all others read as the pattern 128,0,128,0.
`default_nettype none

`include "background_frame_key_macros.svh"

module background_frame_key (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire bfk_pkg::bfk_req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output bfk_pkg::bfk_rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [bfk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [bfk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   import bfk_pkg::*;

   bfk_cfg_type cfg;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] fill_ff, fill_in;
   logic armed_ff, armed_in;
   logic capturing_ff, capturing_in;

   logic s1_valid_ff, s1_valid_in;
   bfk_req_type s1_req_ff;
   logic s1_compare_ff;
   logic s1_from_ram_ff;

   logic rsp_valid_ff, rsp_valid_in;
   bfk_rsp_type rsp_data_ff, rsp_data_in;

   logic req_beat, pixel_beat, arm_beat;
   logic s1_adv;
   logic cap_now, in_store;
   logic wr_en, rd_en;
   logic [31:0] wr_word, ram_word, stored;
   logic [POS_W-1:0] pos_next;
   logic near0, near1, near2, hit;

   bfk_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_beat = req_valid && !req_stall;
   assign arm_beat = req_beat && (req_data.opcode == OP_ARM);
   assign pixel_beat = req_beat && (req_data.opcode == OP_PIXEL);

   assign cap_now = (pos_ff == '0) ? armed_ff : capturing_ff;
   assign in_store = pos_ff < POS_W'(STORE_WORDS);
   assign wr_en = pixel_beat && in_store && cap_now;
   assign rd_en = pixel_beat && in_store && !cap_now;
   assign wr_word = {req_data.lane3, req_data.lane2, req_data.lane1, req_data.lane0};
   assign pos_next = pos_ff + POS_W'(1);

   bfk_ram #(
      .WIDTH(32),
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(pos_ff[ADDR_W-1:0]),
      .wr_data(wr_word),
      .rd_en(rd_en),
      .rd_addr(pos_ff[ADDR_W-1:0]),
      .rd_data(ram_word)
   );

   always_comb begin
      pos_in = pos_ff;
      fill_in = fill_ff;
      armed_in = armed_ff;
      capturing_in = capturing_ff;
      if (arm_beat) begin
         armed_in = 1'b1;
      end else if (pixel_beat) begin
         if (pos_ff == '0) begin
            armed_in = 1'b0;
         end
         if (req_data.last_in_frame) begin
            pos_in = '0;
            capturing_in = 1'b0;
         end else begin
            capturing_in = cap_now;
            if (in_store) begin
               pos_in = pos_next;
            end
         end
         if (wr_en && (pos_next > fill_ff)) begin
            fill_in = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fill_ff <= '0;
         armed_ff <= 1'b0;
         capturing_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         armed_ff <= armed_in;
         capturing_ff <= capturing_in;
      end
   end

   assign s1_valid_in = pixel_beat ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_beat) begin
         s1_req_ff <= req_data;
         s1_compare_ff <= rd_en;
         s1_from_ram_ff <= pos_ff < fill_ff;
      end
   end

   assign stored = s1_from_ram_ff ? ram_word : BG_RESET_WORD;

   // A lane matches when stored - range < lane < stored + range.
   assign near0 = ({2'b00, s1_req_ff.lane0} + {1'b0, cfg.u_range}) > {2'b00, stored[7:0]}
      && ({2'b00, s1_req_ff.lane0} < ({2'b00, stored[7:0]} + {1'b0, cfg.u_range}));
   assign near1 = ({2'b00, s1_req_ff.lane1} + {1'b0, cfg.y_range}) > {2'b00, stored[15:8]}
      && ({2'b00, s1_req_ff.lane1} < ({2'b00, stored[15:8]} + {1'b0, cfg.y_range}));
   assign near2 = ({2'b00, s1_req_ff.lane2} + {1'b0, cfg.v_range}) > {2'b00, stored[23:16]}
      && ({2'b00, s1_req_ff.lane2} < ({2'b00, stored[23:16]} + {1'b0, cfg.v_range}));
   assign hit = s1_compare_ff && near0 && near1 && near2;

   always_comb begin
      rsp_data_in.out_lane0 = s1_req_ff.lane0;
      rsp_data_in.out_lane1 = s1_req_ff.lane1;
      rsp_data_in.out_lane2 = s1_req_ff.lane2;
      rsp_data_in.out_lane3 = s1_req_ff.lane3;
      rsp_data_in.out_last = s1_req_ff.last_in_frame;
      rsp_data_in.is_background = hit;
      if (hit) begin
         unique case (cfg.pixel_mode)
            MODE_YUV: begin
               rsp_data_in.out_lane0 = LANE_MID;
               rsp_data_in.out_lane1 = LANE_ZERO;
               rsp_data_in.out_lane2 = LANE_MID;
               rsp_data_in.out_lane3 = LANE_ZERO;
            end
            MODE_RGBA: begin
               rsp_data_in.out_lane0 = LANE_ZERO;
               rsp_data_in.out_lane1 = LANE_ZERO;
               rsp_data_in.out_lane2 = LANE_ZERO;
            end
            default: begin
               rsp_data_in.is_background = hit;
            end
         endcase
      end
   end

   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `BFK_ASSERT_NOW(a_no_rw_same_beat, clock, reset, wr_en, !rd_en)
   `BFK_ASSERT_NOW(a_pos_bounded, clock, reset, 1'b1, pos_ff <= POS_W'(STORE_WORDS))
   `BFK_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)
   `BFK_ASSERT_NOW(a_keyed_lanes, clock, reset, rsp_valid_ff && rsp_data_ff.is_background,
      (rsp_data_ff.out_lane1 == LANE_ZERO) && (rsp_data_ff.out_lane0 == rsp_data_ff.out_lane2))

endmodule

`default_nettype wire
